// ===== sv/age_ordered_slot_buffer_defines.svh =====
// Assertion macros used by the checker file of the slot buffer.
`ifndef AGE_ORDERED_SLOT_BUFFER_DEFINES_SVH
`define AGE_ORDERED_SLOT_BUFFER_DEFINES_SVH

// Checked on every rising edge of clk, suspended while rst is high.
`define AOSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define AOSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/aosb_pkg.sv =====
`default_nettype none
package aosb_pkg;

  localparam int SLOTS      = 8;
  localparam int DATA_WIDTH = 32;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int AGE_W   = 4;
  localparam int COUNT_W = 4;
  localparam int CFG_W   = 4;

  localparam logic [AGE_W-1:0]   AGE_MAX   = 4'd15;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;

  // Field widths of one input and one result beat.
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int OSLOT_W   = 3;
  localparam int FILL_W    = 4;
  localparam int OUT_DATA_W = 40;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic apply;
    logic emit;
  } aosb_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } aosb_stat_t;

endpackage
`default_nettype wire

// ===== sv/aosb_ram.sv =====
`default_nettype none
module aosb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/aosb_ctrl.sv =====
`default_nettype none
module aosb_ctrl
  import aosb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire aosb_stat_t stat,
  output aosb_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // The result waits here until the output register has room.
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/aosb_dp.sv =====
`default_nettype none
module aosb_dp
  import aosb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire aosb_cmd_t            cmd,
  output aosb_stat_t                stat,
  input  wire logic                 in_mode,
  input  wire logic [VALUE_W-1:0]   in_value,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_W-1:0]     cfg_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STATUS_W-1:0]       out_status,
  output logic [OSLOT_W-1:0]        out_slot,
  output logic [VALUE_W-1:0]        out_taken,
  output logic [FILL_W-1:0]         out_fill
);

  logic [CFG_W-1:0]      slots_in_use;
  logic [AGE_W-1:0]      ages [SLOTS];
  logic [COUNT_W-1:0]    count;

  logic                  op_mode;
  logic [DATA_WIDTH-1:0] op_value;
  logic [CNT_W-1:0]      k;
  logic                  found_empty;
  logic [SLOT_W-1:0]     empty_idx;
  logic [AGE_W-1:0]      best_age;
  logic [SLOT_W-1:0]     best_idx;
  logic [STATUS_W-1:0]   res_status;
  logic [SLOT_W-1:0]     res_idx;
  logic                  res_take;

  logic [CNT_W-1:0]      live_n;
  logic [CNT_W-1:0]      k_inc;
  logic [AGE_W-1:0]      age_k;
  logic                  put_ok;
  logic                  take_ok;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH+VALUE_W-1:0] value_wide;
  logic [DATA_WIDTH+VALUE_W-1:0] taken_wide;
  logic [SLOT_W+OSLOT_W-1:0]     slot_wide;

  // Zero means one slot, anything above the built count means all of them.
  always_comb begin
    if (slots_in_use == '0) begin
      live_n = CNT_W'(1);
    end else if (int'(slots_in_use) > SLOTS) begin
      live_n = CNT_W'(SLOTS);
    end else begin
      live_n = CNT_W'(slots_in_use);
    end
  end

  assign k_inc          = k + 1'b1;
  assign age_k          = ages[k[SLOT_W-1:0]];
  assign stat.scan_last = (k_inc == live_n);
  assign stat.out_free  = !out_valid || out_ready;

  assign put_ok  = (int'(count) < int'(live_n)) && found_empty;
  assign take_ok = (best_age != '0);

  assign value_wide = {{DATA_WIDTH{1'b0}}, in_value};
  assign taken_wide = {{VALUE_W{rd_data[DATA_WIDTH-1]}}, rd_data};
  assign slot_wide  = {{OSLOT_W{1'b0}}, res_idx};

  aosb_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(SLOTS)
  ) u_data_ram (
    .clk  (clk),
    .we   (cmd.apply && op_mode == MODE_PUT && put_ok),
    .waddr(empty_idx),
    .wdata(op_value),
    .re   (cmd.apply && op_mode == MODE_TAKE && take_ok),
    .raddr(best_idx),
    .rdata(rd_data)
  );

  // Operation registers and the running scan results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode     <= in_mode;
      op_value    <= value_wide[DATA_WIDTH-1:0];
      k           <= '0;
      found_empty <= 1'b0;
      empty_idx   <= '0;
      best_age    <= '0;
      best_idx    <= '0;
    end else if (cmd.scan_step) begin
      k <= k_inc;
      if (age_k == '0 && !found_empty) begin
        found_empty <= 1'b1;
        empty_idx   <= k[SLOT_W-1:0];
      end
      if (age_k > best_age) begin
        best_age <= age_k;
        best_idx <= k[SLOT_W-1:0];
      end
    end
    if (cmd.apply) begin
      res_take <= 1'b0;
      if (op_mode == MODE_PUT) begin
        res_status <= put_ok ? ST_DONE : ST_FULL;
        res_idx    <= put_ok ? empty_idx : '0;
      end else begin
        res_status <= take_ok ? ST_DONE : ST_EMPTY;
        res_idx    <= take_ok ? best_idx : '0;
        res_take   <= take_ok;
      end
    end
  end

  // Slot ages, fill count and the slot limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CFG_RESET;
      count        <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        ages[i] <= '0;
      end
    end else if (cfg_write) begin
      slots_in_use <= cfg_value;
      count        <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        ages[i] <= '0;
      end
    end else if (cmd.apply) begin
      if (op_mode == MODE_PUT && put_ok) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (i < int'(live_n) && ages[i] != '0 && ages[i] != AGE_MAX) begin
            ages[i] <= ages[i] + 1'b1;
          end
        end
        ages[empty_idx] <= AGE_W'(1);
        if (count != COUNT_MAX) begin
          count <= count + 1'b1;
        end
      end else if (op_mode == MODE_TAKE && take_ok) begin
        ages[best_idx] <= '0;
        if (count != '0) begin
          count <= count - 1'b1;
        end
      end
    end
  end

  // Output register: holds a result beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_status;
      out_slot   <= slot_wide[OSLOT_W-1:0];
      out_taken  <= res_take ? taken_wide[VALUE_W-1:0] : '0;
      out_fill   <= count;
    end
  end

endmodule
`default_nettype wire

// ===== sv/age_ordered_slot_buffer.sv =====
// Age-ordered slot buffer.
// Input beats arrive on the s_ group: s_tuser is the mode (put or take) and
// s_tdata the data word for a put. Every accepted beat yields exactly one
// result beat on the m_ group: m_tuser is the status, m_tdata carries the
// slot, the taken data word and the fill count after the operation.
// The user must write the slot limit on the cfg_ channel only while the block
// is idle; the block does not enforce this. A write also empties the buffer.
// cfg_ready is always high. The slot scan compares one slot age per cycle to
// find the free slot or the oldest one, over n slots, where n is the number
// of slots in use (1 to 8). A new beat is accepted only once the result of
// the last one has been loaded into the output register.
// Reset clears all ages, the fill count and the output valid, and sets the
// slot limit to 8; the block is ready in the first cycle after reset.
// When the receiver stalls, the result holds in the output register; the
// next beat is still accepted and scanned, and its result waits in the
// controller until the output register is free.
`default_nettype none
module age_ordered_slot_buffer
  import aosb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [VALUE_W-1:0]    s_tdata,   // [31:0] value
  input  wire logic                  s_tuser,   // [0] mode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [2:0] slot, [34:3] taken_value,
                                                // [38:35] fill_count, [39] zero
  output logic [STATUS_W-1:0]        m_tuser,   // [1:0] status
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data   // [3:0] slots_in_use
);

  aosb_cmd_t  cmd;
  aosb_stat_t stat;

  logic [OSLOT_W-1:0] out_slot;
  logic [VALUE_W-1:0] out_taken;
  logic [FILL_W-1:0]  out_fill;

  assign cfg_ready = 1'b1;

  aosb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  aosb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_mode   (s_tuser),
    .in_value  (s_tdata),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_status(m_tuser),
    .out_slot  (out_slot),
    .out_taken (out_taken),
    .out_fill  (out_fill)
  );

  assign m_tdata = {1'b0, out_fill, out_taken, out_slot};

endmodule
`default_nettype wire

// ===== sv/aosb_checker.sv =====
`default_nettype none
`include "age_ordered_slot_buffer_defines.svh"
module aosb_checker
  import aosb_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [STATUS_W-1:0]   m_tuser
);

  `AOSB_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !m_tvalid, "result valid after reset")

  `AOSB_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

  `AOSB_ASSERT(a_status_code, m_tvalid |-> m_tuser == ST_DONE || m_tuser == ST_FULL || m_tuser == ST_EMPTY, "unknown status")

  `AOSB_ASSERT(a_refused_zero, m_tvalid && m_tuser != ST_DONE |-> m_tdata[34:0] == '0, "refused beat carries slot or data")

  `AOSB_ASSERT(a_fill_bound, m_tvalid |-> int'(m_tdata[38:35]) <= SLOTS && !m_tdata[39], "fill count beyond slot count")

endmodule

bind age_ordered_slot_buffer aosb_checker u_aosb_checker (.*);
`default_nettype wire

// ===== tb/slot_buffer_checker.sv =====
`timescale 1ns / 100ps
module slot_buffer_checker
  import aosb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [VALUE_W-1:0]    s_tdata,   // [31:0] value
  input  wire logic                  s_tuser,   // [0] mode
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] slot, [34:3] taken_value,
                                                // [38:35] fill_count, [39] zero
  input  wire logic [STATUS_W-1:0]   m_tuser,   // [1:0] status
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data,  // [3:0] slots_in_use
  output int                         errors,
  output int                         outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OSLOT_W-1:0]  slot;
    logic [VALUE_W-1:0]  taken;
    logic [FILL_W-1:0]   fill;
  } slot_result_t;

  logic [VALUE_W-1:0] slot_words [SLOTS];
  logic [AGE_W-1:0]   slot_ages [SLOTS];
  logic [COUNT_W-1:0] fill_q;
  logic [CFG_W-1:0]   limit_q;

  slot_result_t pending_results [$];
  int mismatch_count = 0;
  int beat_index = 0;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
             beat_index, what, got, want);
    mismatch_count++;
  endtask

  function automatic void empty_buffer();
    for (int k = 0; k < SLOTS; k++) slot_ages[k] = '0;
    fill_q = '0;
  endfunction

  // One put or take on the predicted buffer; returns the result it produces.
  function automatic slot_result_t age_order_step(input logic mode,
                                                  input logic [VALUE_W-1:0] value);
    slot_result_t r;
    int live;
    int pick;
    logic [AGE_W-1:0] best_age;
    r = '0;
    pick = -1;
    // A limit of zero behaves as one slot, anything above the build as all of them.
    live = (limit_q == '0) ? 1 : ((int'(limit_q) > SLOTS) ? SLOTS : int'(limit_q));
    if (mode == MODE_PUT) begin
      for (int k = 0; k < live; k++) begin
        if (slot_ages[k] == '0 && pick < 0) pick = k;
      end
      if (int'(fill_q) >= live || pick < 0) begin
        r.status = ST_FULL;
      end else begin
        for (int k = 0; k < live; k++) begin
          if (slot_ages[k] != '0 && slot_ages[k] < AGE_MAX) slot_ages[k]++;
        end
        slot_ages[pick] = AGE_W'(1);
        slot_words[pick] = value;
        if (fill_q < COUNT_MAX) fill_q++;
        r.status = ST_DONE;
        r.slot = OSLOT_W'(pick);
      end
    end else begin
      best_age = '0;
      for (int k = 0; k < live; k++) begin
        if (slot_ages[k] > best_age) begin
          best_age = slot_ages[k];
          pick = k;
        end
      end
      if (pick < 0) begin
        r.status = ST_EMPTY;
      end else begin
        slot_ages[pick] = '0;
        if (fill_q > '0) fill_q--;
        r.status = ST_DONE;
        r.slot = OSLOT_W'(pick);
        r.taken = slot_words[pick];
      end
    end
    r.fill = fill_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    slot_result_t want;
    if (rst) begin
      limit_q = CFG_RESET;
      for (int k = 0; k < SLOTS; k++) slot_words[k] = '0;
      empty_buffer();
      pending_results.delete();
    end else begin
      // A limit write also empties the buffer; the data words stay.
      if (cfg_valid && cfg_ready) begin
        limit_q = cfg_data;
        empty_buffer();
      end
      if (s_tvalid && s_tready) pending_results.push_back(age_order_step(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("with nothing expected", 64'(m_tdata), '0);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.status)
            report_mismatch("status", 64'(m_tuser), 64'(want.status));
          if (m_tdata[OSLOT_W-1:0] !== want.slot)
            report_mismatch("slot", 64'(m_tdata[OSLOT_W-1:0]), 64'(want.slot));
          if (m_tdata[OSLOT_W +: VALUE_W] !== want.taken)
            report_mismatch("taken_value", 64'(m_tdata[OSLOT_W +: VALUE_W]),
                            64'(want.taken));
          if (m_tdata[OSLOT_W+VALUE_W +: FILL_W] !== want.fill)
            report_mismatch("fill_count", 64'(m_tdata[OSLOT_W+VALUE_W +: FILL_W]),
                            64'(want.fill));
        end
        beat_index++;
      end
    end
    outstanding <= pending_results.size();
    errors <= mismatch_count;
  end

endmodule

// ===== tb/tb_age_ordered_slot_buffer.sv =====
`timescale 1ns / 100ps
module tb_age_ordered_slot_buffer;
  import aosb_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [VALUE_W-1:0]    s_tdata = '0;      // [31:0] value
  logic                  s_tuser = MODE_PUT; // [0] mode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;           // [2:0] slot, [34:3] taken_value,
                                            // [38:35] fill_count, [39] zero
  logic [STATUS_W-1:0]   m_tuser;           // [1:0] status
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = CFG_RESET; // [3:0] slots_in_use

  int errors;
  int outstanding;
  bit quiet = 1'b0;

  int unsigned phase_limits [8] = '{8, 1, 15, 0, 3, 6, 9, 5};
  logic [VALUE_W-1:0] corner_words [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                           32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                                           32'h0000_0001, 32'hFFFF_FFFE};

  always #4 clk = ~clk;

  age_ordered_slot_buffer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  slot_buffer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Sends one beat, then now and then leaves the input idle for a while.
  task automatic issue(input logic mode, input logic [VALUE_W-1:0] value);
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Holds the input until every owed result has left the block.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_data <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_sink
    int choice;
    forever begin
      @(posedge clk);
      choice = $urandom_range(0, 15);
      if (!quiet && choice == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_tready <= 1'b1;
      if (choice == 1) repeat ($urandom_range(20, 80)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int p;
    int i;
    int k;
    int bias;
    logic [VALUE_W-1:0] word;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Eight slots out of reset: take from empty, fill, overfill, then drain partly.
    issue(MODE_TAKE, $urandom);
    for (k = 0; k < 8; k++) issue(MODE_PUT, corner_words[k]);
    issue(MODE_PUT, $urandom);
    issue(MODE_TAKE, $urandom);
    issue(MODE_PUT, 32'h1234_5678);
    issue(MODE_TAKE, $urandom);

    // A limit of zero acts as a single slot.
    drain();
    write_limit(4'd0);
    issue(MODE_PUT, 32'hDEAD_BEEF);
    issue(MODE_PUT, 32'h0BAD_F00D);
    issue(MODE_TAKE, $urandom);
    issue(MODE_TAKE, $urandom);

    // A limit write empties a buffer that still holds a word.
    issue(MODE_PUT, 32'hCAFE_0001);
    drain();
    write_limit(4'd3);
    issue(MODE_TAKE, $urandom);

    for (p = 0; p < 8; p++) begin
      drain();
      if (p == 7) quiet = 1'b1;
      write_limit((p == 5) ? CFG_W'($urandom_range(0, 15)) : CFG_W'(phase_limits[p]));
      bias = 50;
      for (i = 0; i < 200; i++) begin
        // Swing the put share so the buffer keeps running into full and empty.
        if (i % 24 == 0) begin
          case ($urandom_range(0, 2))
            0: bias = 20;
            1: bias = 50;
            default: bias = 85;
          endcase
        end
        case ($urandom_range(0, 7))
          0: word = 32'h8000_0000;
          1: word = 32'h7FFF_FFFF;
          2: word = '0;
          3: word = '1;
          default: word = $urandom;
        endcase
        issue(($urandom_range(0, 99) < bias) ? MODE_PUT : MODE_TAKE, word);
      end
    end

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : run_limit
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
